// File: rtl/esl_pkg.sv
// Package for the edge shrink step limit block.
// Holds the fixed-point constants, register indexes and reset values.
// No dependencies.
package esl_pkg;

   localparam int FRACTION_BITS = 24;
   localparam int STEP_W = FRACTION_BITS + 1;
   localparam int DISC_SHIFT = 2 * FRACTION_BITS - 2;

   localparam int COORD_W = 32;
   localparam int WORD_W = 64;
   localparam int WIDE_W = 128;
   localparam int RATIO_W = 16;
   localparam int EPS_W = 41;
   localparam int CSR_W = 41;
   localparam int CSR_IDX_W = 2;

   localparam int MUL_CNT_W = $clog2(WORD_W);
   localparam int ROOT_CNT_W = $clog2(WORD_W);
   localparam int DIV_CNT_W = $clog2(FRACTION_BITS);

   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_RATIO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_EPS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISC_EPS = 2'd2;

   localparam logic [RATIO_W-1:0] SHRINK_RATIO_RESET = 16'd13107;
   localparam logic [EPS_W-1:0] SPEED_EPS_RESET = 41'd281474977;
   localparam logic [EPS_W-1:0] DISC_EPS_RESET = 41'd281474977;

   localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRACTION_BITS;

endpackage

// File: rtl/esl_mul.sv
// Bit-serial 64 by 64 multiplier, one multiplier bit per cycle, MSB first.
// Depends on esl_pkg.
module esl_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [esl_pkg::WORD_W-1:0]  mcand,
   input  logic [esl_pkg::WORD_W-1:0]  mplier,
   output logic [esl_pkg::WIDE_W-1:0]  product,
   output logic                        done
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [esl_pkg::MUL_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [esl_pkg::WORD_W-1:0]     m_ff, m_in;
   logic [esl_pkg::WORD_W-1:0]     x_ff, x_in;
   logic [esl_pkg::WIDE_W-1:0]     prod_ff, prod_in;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      m_in    = m_ff;
      x_in    = x_ff;
      prod_in = prod_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         m_in    = mcand;
         x_in    = mplier;
         prod_in = '0;
      end else if (busy_ff) begin
         prod_in = {prod_ff[esl_pkg::WIDE_W-2:0], 1'b0}
                 + (x_ff[esl_pkg::WORD_W-1] ? {{esl_pkg::WORD_W{1'b0}}, m_ff} : '0);
         x_in    = {x_ff[esl_pkg::WORD_W-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      m_ff    <= m_in;
      x_ff    <= x_in;
      prod_ff <= prod_in;
   end

   assign product = prod_ff;
   assign done    = done_ff;

endmodule

// File: rtl/esl_sqrt.sv
// Digit-by-digit integer square root of a 128-bit radicand, one root bit per cycle.
// Depends on esl_pkg.
module esl_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [esl_pkg::WIDE_W-1:0]  radicand,
   output logic [esl_pkg::WORD_W-1:0]  root,
   output logic                        done
);

   localparam int REM_W = esl_pkg::WORD_W + 2;
   localparam int SH_W = REM_W + 2;

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [esl_pkg::ROOT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [esl_pkg::WIDE_W-1:0]     rad_ff, rad_in;
   logic [REM_W-1:0]               rem_ff, rem_in;
   logic [esl_pkg::WORD_W-1:0]     root_ff, root_in;
   logic [SH_W-1:0]                rem_sh;
   logic [SH_W-1:0]                trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      rem_sh  = {rem_ff, rad_ff[esl_pkg::WIDE_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '1;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[esl_pkg::WIDE_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[esl_pkg::WORD_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[esl_pkg::WORD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

// File: rtl/esl_div.sv
// Restoring fractional divider, one quotient bit per cycle, for numerator below divisor.
// Depends on esl_pkg.
module esl_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [esl_pkg::WORD_W-1:0]         numer,
   input  logic [esl_pkg::WORD_W-1:0]         denom,
   output logic [esl_pkg::FRACTION_BITS-1:0]  quotient,
   output logic                               done
);

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [esl_pkg::DIV_CNT_W-1:0]      cnt_ff, cnt_in;
   logic [esl_pkg::WORD_W-1:0]         rem_ff, rem_in;
   logic [esl_pkg::WORD_W-1:0]         den_ff, den_in;
   logic [esl_pkg::FRACTION_BITS-1:0]  quo_ff, quo_in;
   logic [esl_pkg::WORD_W:0]           rem2;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      rem2    = {rem_ff, 1'b0};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = esl_pkg::DIV_CNT_W'(esl_pkg::FRACTION_BITS - 1);
         rem_in  = numer;
         den_in  = denom;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (rem2 >= {1'b0, den_ff}) begin
            rem_in = esl_pkg::WORD_W'(rem2 - {1'b0, den_ff});
            quo_in = {quo_ff[esl_pkg::FRACTION_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem2[esl_pkg::WORD_W-1:0];
            quo_in = {quo_ff[esl_pkg::FRACTION_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: rtl/edge_shrink_step_limit.sv
// Top level of the edge shrink step limit block: sequencer, registers, result port.
// Depends on esl_pkg, esl_mul, esl_sqrt and esl_div.
//
//   channel   direction   ports
//   req       in          req_valid, req_stall, edge and velocity fields, skip, last
//   rsp       out         rsp_valid, rsp_stall, rsp_step_limit
//   csr       in          csr_we, csr_index, csr_wdata
//
// A full edge runs thirteen serial products, each made of a start, 64 multiplier bits,
// a done and an accumulate step, then one check state, the square root, the division,
// one finish state and one idle state before the next transaction is taken.
// An edge that fails a test leaves early; a skipped edge goes straight to the finish state.
// Reset restores the registers and sets the running minimum to 1.0.
// The result waits in an output register, and a new transaction is taken meanwhile.
module edge_shrink_step_limit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [esl_pkg::COORD_W-1:0]    req_edge_dx,
   input  logic signed [esl_pkg::COORD_W-1:0]    req_edge_dy,
   input  logic signed [esl_pkg::COORD_W-1:0]    req_edge_dz,
   input  logic signed [esl_pkg::COORD_W-1:0]    req_rel_vx,
   input  logic signed [esl_pkg::COORD_W-1:0]    req_rel_vy,
   input  logic signed [esl_pkg::COORD_W-1:0]    req_rel_vz,
   input  logic                                  req_edge_skip,
   input  logic                                  req_last_edge,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [esl_pkg::STEP_W-1:0]            rsp_step_limit,
   input  logic                                  csr_we,
   input  logic [esl_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [esl_pkg::CSR_W-1:0]             csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_ACC, ST_CHECK, ST_SQRT_GO, ST_SQRT_WAIT,
      ST_DIV_GO, ST_DIV_WAIT, ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_EV, OP_VV, OP_EE, OP_ALPHA, OP_C, OP_D2, OP_AC
   } op_type;

   localparam int W = esl_pkg::WORD_W;
   localparam int CW = esl_pkg::COORD_W;

   state_type                       state_ff;
   op_type                          op_ff;
   logic [1:0]                      comp_ff;
   logic [CW-1:0]                   em_ff [3];
   logic [CW-1:0]                   vm_ff [3];
   logic [2:0]                      neg_ff;
   logic                            last_ff;
   logic [W-1:0]                    a_ff, ee_ff, pos_ff, negs_ff, c_ff, dmag_ff;
   logic [esl_pkg::WIDE_W-1:0]      q_ff;
   logic [esl_pkg::STEP_W-1:0]      bound_ff, min_ff;
   logic                            rsp_valid_ff;
   logic [esl_pkg::STEP_W-1:0]      rsp_data_ff;
   logic [esl_pkg::RATIO_W-1:0]     ratio_ff;
   logic [esl_pkg::EPS_W-1:0]       speed_eps_ff, disc_eps_ff;

   logic [CW-1:0]                   mag_e [3];
   logic [CW-1:0]                   mag_v [3];
   logic signed [CW-1:0]            in_e [3];
   logic signed [CW-1:0]            in_v [3];
   logic [W-1:0]                    mul_m, mul_x;
   logic [esl_pkg::WIDE_W-1:0]      product;
   logic                            mul_done, sqrt_done, div_done;
   logic [W-1:0]                    root;
   logic [esl_pkg::FRACTION_BITS-1:0] quotient;
   logic [W-1:0]                    numer;
   logic [esl_pkg::STEP_W-1:0]      new_min;
   logic                            accept;

   assign in_e[0] = req_edge_dx;
   assign in_e[1] = req_edge_dy;
   assign in_e[2] = req_edge_dz;
   assign in_v[0] = req_rel_vx;
   assign in_v[1] = req_rel_vy;
   assign in_v[2] = req_rel_vz;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_e[i] = in_e[i][CW-1] ? CW'(-in_e[i]) : CW'(in_e[i]);
         mag_v[i] = in_v[i][CW-1] ? CW'(-in_v[i]) : CW'(in_v[i]);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      unique case (op_ff)
         OP_EV: begin
            mul_m = W'(em_ff[comp_ff]);
            mul_x = W'(vm_ff[comp_ff]);
         end
         OP_VV: begin
            mul_m = W'(vm_ff[comp_ff]);
            mul_x = W'(vm_ff[comp_ff]);
         end
         OP_EE: begin
            mul_m = W'(em_ff[comp_ff]);
            mul_x = W'(em_ff[comp_ff]);
         end
         OP_ALPHA: begin
            mul_m = W'(ratio_ff);
            mul_x = W'(ratio_ff);
         end
         OP_C: begin
            mul_m = ee_ff;
            mul_x = c_ff;
         end
         OP_D2: begin
            mul_m = dmag_ff;
            mul_x = dmag_ff;
         end
         OP_AC: begin
            mul_m = a_ff;
            mul_x = c_ff;
         end
         default: begin
            mul_m = '0;
            mul_x = '0;
         end
      endcase
   end

   esl_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == ST_MUL_GO),
      .mcand   (mul_m),
      .mplier  (mul_x),
      .product (product),
      .done    (mul_done)
   );

   esl_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_SQRT_GO),
      .radicand (q_ff),
      .root     (root),
      .done     (sqrt_done)
   );

   esl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_DIV_GO),
      .numer    (dmag_ff),
      .denom    (a_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   assign numer   = dmag_ff - root;
   assign new_min = (bound_ff < min_ff) ? bound_ff : min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_EV;
         comp_ff      <= '0;
         min_ff       <= esl_pkg::STEP_ONE;
         rsp_valid_ff <= 1'b0;
         ratio_ff     <= esl_pkg::SHRINK_RATIO_RESET;
         speed_eps_ff <= esl_pkg::SPEED_EPS_RESET;
         disc_eps_ff  <= esl_pkg::DISC_EPS_RESET;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               esl_pkg::CSR_SHRINK_RATIO: ratio_ff <= csr_wdata[esl_pkg::RATIO_W-1:0];
               esl_pkg::CSR_SPEED_EPS:    speed_eps_ff <= csr_wdata[esl_pkg::EPS_W-1:0];
               esl_pkg::CSR_DISC_EPS:     disc_eps_ff <= csr_wdata[esl_pkg::EPS_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  for (int i = 0; i < 3; i++) begin
                     em_ff[i]  <= mag_e[i];
                     vm_ff[i]  <= mag_v[i];
                     neg_ff[i] <= in_e[i][CW-1] ^ in_v[i][CW-1];
                  end
                  last_ff  <= req_last_edge;
                  bound_ff <= esl_pkg::STEP_ONE;
                  a_ff     <= '0;
                  ee_ff    <= '0;
                  pos_ff   <= '0;
                  negs_ff  <= '0;
                  comp_ff  <= '0;
                  op_ff    <= OP_EV;
                  state_ff <= req_edge_skip ? ST_FINISH : ST_MUL_GO;
               end
            end
            ST_MUL_GO: state_ff <= ST_MUL_WAIT;
            ST_MUL_WAIT: begin
               if (mul_done) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               state_ff <= ST_MUL_GO;
               unique case (op_ff)
                  OP_EV: begin
                     if (neg_ff[comp_ff]) begin
                        negs_ff <= negs_ff + product[W-1:0];
                     end else begin
                        pos_ff <= pos_ff + product[W-1:0];
                     end
                     op_ff <= OP_VV;
                  end
                  OP_VV: begin
                     a_ff  <= a_ff + product[W-1:0];
                     op_ff <= OP_EE;
                  end
                  OP_EE: begin
                     ee_ff <= ee_ff + product[W-1:0];
                     if (comp_ff == 2'd2) begin
                        if (a_ff < W'(speed_eps_ff) || pos_ff > negs_ff) begin
                           state_ff <= ST_FINISH;
                        end
                        dmag_ff <= negs_ff - pos_ff;
                        op_ff   <= OP_ALPHA;
                     end else begin
                        comp_ff <= comp_ff + 1'b1;
                        op_ff   <= OP_EV;
                     end
                  end
                  OP_ALPHA: begin
                     c_ff  <= W'(33'h1_0000_0000 - product[32:0]);
                     op_ff <= OP_C;
                  end
                  OP_C: begin
                     c_ff  <= product[95:32];
                     op_ff <= OP_D2;
                  end
                  OP_D2: begin
                     q_ff  <= product;
                     op_ff <= OP_AC;
                  end
                  OP_AC: begin
                     q_ff <= q_ff - product;
                     state_ff <= (product > q_ff) ? ST_FINISH : ST_CHECK;
                  end
                  default: state_ff <= ST_FINISH;
               endcase
            end
            ST_CHECK: begin
               if ((q_ff >> esl_pkg::DISC_SHIFT) < esl_pkg::WIDE_W'(disc_eps_ff)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_SQRT_GO;
               end
            end
            ST_SQRT_GO: state_ff <= ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
               if (sqrt_done) begin
                  dmag_ff  <= numer;
                  state_ff <= (numer >= a_ff) ? ST_FINISH : ST_DIV_GO;
               end
            end
            ST_DIV_GO: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  bound_ff <= {1'b0, quotient};
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!last_ff) begin
                  min_ff   <= new_min;
                  state_ff <= ST_IDLE;
               end else if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= new_min;
                  min_ff       <= esl_pkg::STEP_ONE;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_limit = rsp_data_ff;

endmodule
